/* rtl/core/btgr_pkg.sv */
// ----------------------------------------------------------------------------
// btgr_pkg
// Shared types, codes, widths and the 8x12 font ROM of the glyph renderer.
// ----------------------------------------------------------------------------
package btgr_pkg;

  localparam int GlyphCount   = 128;
  localparam int GlyphRows    = 12;
  localparam int GlyphCols    = 8;
  localparam int MaxPixelSize = 10;
  localparam int QueueDepth   = 2;
  localparam int FontWords    = 384;
  localparam int FontAddrW    = 12;
  localparam int SumW         = 18;
  localparam int CoordW       = 16;
  localparam int StepW        = 5;
  localparam int SizeW        = 4;
  localparam int CfgIndexW    = 2;
  localparam int CfgDataW     = 4;
  localparam int InDataW      = 48;
  localparam int OutDataW     = 56;

  // input tdata layout
  localparam int InAnchorXLsb = 0;
  localparam int InAnchorYLsb = 16;
  localparam int InLengthLsb  = 32;
  localparam int InCodeLsb    = 40;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdDraw  = 1'b1;

  localparam logic [1:0] DirRight = 2'd0;
  localparam logic [1:0] DirDown  = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;
  localparam logic [1:0] DirUp    = 2'd3;

  localparam logic [1:0] JustNone = 2'd0;
  localparam logic [1:0] JustHalf = 2'd1;

  localparam logic [CfgIndexW-1:0] RegDirection = 2'd0;
  localparam logic [CfgIndexW-1:0] RegPixelSize = 2'd1;
  localparam logic [CfgIndexW-1:0] RegJustHoriz = 2'd2;
  localparam logic [CfgIndexW-1:0] RegJustVert  = 2'd3;

  // one character handed from the front to the back
  typedef struct packed {
    logic signed [CoordW-1:0] pen_x;
    logic signed [CoordW-1:0] pen_y;
    logic [1:0]               dir;
    logic [SizeW-1:0]         size;
    logic [FontAddrW-1:0]     base;
    logic                     blank;
  } btgr_glyph_t;

  localparam logic [31:0] FontRom [FontWords] = '{
    32'd0, 32'd0, 32'd0, 32'd2177072640, 32'd2579333541, 32'd32451, 32'd4294934016,
    32'd3888381915,
    32'd32511, 32'd1998716928, 32'd1048543103, 32'd2076, 32'd1042024448, 32'd473857919,
    32'd8, 32'd1010571264,
    32'd417851391, 32'd32280, 32'd2117867520, 32'd410976255, 32'd32280, 32'd0,
    32'd1014922812, 32'd0,
    32'd4294967295, 32'd3280044483, 32'd4294967295, 32'd2117861376, 32'd1715618406,
    32'd15486, 32'd2177105919, 32'd2579348889,
    32'd4294951809, 32'd1550875648, 32'd858988366, 32'd7731, 32'd1717976064,
    32'd2115517542, 32'd6168, 32'd2560161792,
    32'd504895736, 32'd3615, 32'd4274454016, 32'd3871786694, 32'd223207, 32'd3675783168,
    32'd2129127294, 32'd6363,
    32'd117637376, 32'd119504671, 32'd259, 32'd1885356032, 32'd1887207292, 32'd16480,
    32'd2117867520, 32'd2115508248,
    32'd6204, 32'd1717986816, 32'd26214, 32'd26214, 32'd3688627712, 32'd3638091483,
    32'd55512, 32'd214334976,
    32'd1013343804, 32'd8282928, 32'd0, 32'd2130706432, 32'd32639, 32'd2117867520,
    32'd2115508248, 32'd8263740,
    32'd2117867520, 32'd404232216, 32'd6168, 32'd404232192, 32'd2115508248, 32'd6204,
    32'd402653184, 32'd405831472,
    32'd0, 32'd201326592, 32'd201752326, 32'd0, 32'd0, 32'd2130903811, 32'd0,
    32'd603979776,
    32'd610729830, 32'd0, 32'd134742016, 32'd1044257820, 32'd32639, 32'd2139029504,
    32'd471612990, 32'd2056,
    32'd0, 32'd0, 32'd0, 32'd505285632, 32'd789534, 32'd3084, 32'd1717986816, 32'd36,
    32'd0, 32'd2134259200, 32'd2134259254, 32'd13878, 32'd54397964, 32'd808459779,
    32'd789535, 32'd587202560,
    32'd101455923, 32'd12595, 32'd454757888, 32'd863723278, 32'd28219, 32'd202116096,
    32'd6, 32'd0,
    32'd202911744, 32'd201721350, 32'd12312, 32'd403441152, 32'd405811248, 32'd1548,
    32'd1711276032, 32'd1715273532,
    32'd0, 32'd402653184, 32'd404258328, 32'd0, 32'd0, 32'd0, 32'd400412, 32'd0,
    32'd32512, 32'd0, 32'd0, 32'd0, 32'd7196, 32'd1614807040, 32'd101455920, 32'd259,
    32'd1935883776, 32'd1735355259, 32'd15971, 32'd252446720, 32'd202116108, 32'd16140,
    32'd858988032, 32'd101455920,
    32'd16179, 32'd808656384, 32'd808459312, 32'd7731, 32'd1010315264, 32'd813642550,
    32'd30768, 32'd50544384,
    32'd808460035, 32'd7731, 32'd50732032, 32'd858988291, 32'd7731, 32'd1667464960,
    32'd202911840, 32'd3084,
    32'd858988032, 32'd859512375, 32'd7731, 32'd858988032, 32'd404241971, 32'd3596,
    32'd469762048, 32'd469762076,
    32'd28, 32'd469762048, 32'd469762076, 32'd792604, 32'd202911744, 32'd201720582,
    32'd12312, 32'd0,
    32'd8257662, 32'd0, 32'd403441152, 32'd405823536, 32'd1548, 32'd808656384,
    32'd789528, 32'd3084,
    32'd1667448320, 32'd58424187, 32'd15875, 32'd857607168, 32'd859779891, 32'd13107,
    32'd1717976832, 32'd1717976678,
    32'd16230, 32'd1667644416, 32'd1661141763, 32'd15462, 32'd1714822912, 32'd1717986918,
    32'd7990, 32'd105283328,
    32'd103169574, 32'd32582, 32'd1181122304, 32'd103169574, 32'd3846, 32'd1667644416,
    32'd1668481795, 32'd31846,
    32'd858993408, 32'd858996531, 32'd13107, 32'd202120704, 32'd202116108, 32'd7692,
    32'd808482816, 32'd858992688,
    32'd7731, 32'd912680704, 32'd909516342, 32'd26470, 32'd101060352, 32'd1715865094,
    32'd32614, 32'd2138530560,
    32'd1667459967, 32'd25443, 32'd1734566656, 32'd1937473391, 32'd25443, 32'd1664490496,
    32'd1667457891, 32'd7222,
    32'd1717976832, 32'd101072486, 32'd3846, 32'd1664490496, 32'd2071159651, 32'd7876670,
    32'd1717976832, 32'd1714830950,
    32'd26470, 32'd858988032, 32'd857214467, 32'd7731, 32'd204291840, 32'd202116108,
    32'd7692, 32'd858993408,
    32'd858993459, 32'd7731, 32'd858993408, 32'd858993459, 32'd3102, 32'd1667457792,
    32'd913009507, 32'd13878,
    32'd858993408, 32'd857607198, 32'd13107, 32'd858993408, 32'd202120755, 32'd7692,
    32'd426999552, 32'd1174801432,
    32'd32611, 32'd202128384, 32'd202116108, 32'd15372, 32'd50397184, 32'd806882310,
    32'd16480, 32'd808467456,
    32'd808464432, 32'd15408, 32'd1664490504, 32'd0, 32'd0, 32'd0, 32'd0, 32'd16711680,
    32'd1575948, 32'd0, 32'd0, 32'd0, 32'd859713566, 32'd28211, 32'd101058304,
    32'd1717986878,
    32'd15206, 32'd0, 32'd50541342, 32'd7731, 32'd808466432, 32'd858993470, 32'd28211,
    32'd0,
    32'd54473502, 32'd7731, 32'd104209408, 32'd101064454, 32'd3846, 32'd0, 32'd858993518,
    32'd506671166,
    32'd101058304, 32'd1717988918, 32'd26470, 32'd1579008, 32'd404232222, 32'd32280,
    32'd3158016, 32'd808464444,
    32'd506671920, 32'd101058304, 32'd907949670, 32'd26470, 32'd404233728, 32'd404232216,
    32'd32280, 32'd0,
    32'd1802201919, 32'd25451, 32'd0, 32'd858993439, 32'd13107, 32'd0, 32'd858993438,
    32'd7731,
    32'd0, 32'd1717986875, 32'd252067430, 32'd0, 32'd858993518, 32'd2016427571, 32'd0,
    32'd107902519,
    32'd3846, 32'd0, 32'd403059486, 32'd7731, 32'd100925440, 32'd101058111, 32'd7222,
    32'd0,
    32'd858993459, 32'd28211, 32'd0, 32'd858993459, 32'd3102, 32'd0, 32'd1802199907,
    32'd13878,
    32'd0, 32'd471610979, 32'd25398, 32'd0, 32'd1717986918, 32'd253243452, 32'd0,
    32'd102248767,
    32'd16163, 32'd202127360, 32'd201720582, 32'd14348, 32'd404232192, 32'd404226072,
    32'd6168, 32'd202114816,
    32'd202911768, 32'd1804, 32'd1935396352, 32'd0, 32'd0, 32'd134217728, 32'd1667446300,
    32'd127
  };

  // byte lookup in the packed font, zero beyond the end of the table
  function automatic logic [GlyphCols-1:0] font_byte(input logic [FontAddrW-1:0] addr);
    logic [FontAddrW-3:0] word;
    logic [31:0]          bits;
    word = addr[FontAddrW-1:2];
    if (int'(word) >= FontWords) begin
      return '0;
    end
    bits = FontRom[word[8:0]];
    return bits[{addr[1:0], 3'b000} +: GlyphCols];
  endfunction

  // clamp to the signed 16-bit coordinate range
  function automatic logic signed [CoordW-1:0] sat16(input logic signed [SumW-1:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7FFF;
    end
    if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[CoordW-1:0];
  endfunction

endpackage

/* rtl/core/btgr_front.sv */
// ----------------------------------------------------------------------------
// btgr_front
// Takes input transactions, holds the settings and the pen, justifies on a
// start and hands each character with its pen position to the queue.
// ----------------------------------------------------------------------------
module btgr_front import btgr_pkg::*; #(
  parameter int GLYPH_COUNT = GlyphCount,
  parameter int GLYPH_ROWS  = GlyphRows
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output btgr_glyph_t          q_data_o
);

  localparam int DvW = $clog2(GLYPH_ROWS * MaxPixelSize + 1);
  localparam int DhW = 15;
  localparam logic [DvW-1:0] RowsV = DvW'(GLYPH_ROWS);

  logic [1:0]       dir_q;
  logic [SizeW-1:0] size_q;
  logic [1:0]       jh_q, jv_q;
  logic signed [CoordW-1:0] pen_x_q, pen_x_d, pen_y_q, pen_y_d;

  logic                     accept;
  logic signed [CoordW-1:0] anchor_x, anchor_y;
  logic [7:0]               text_len;
  logic [6:0]               code;
  logic [SizeW-1:0]         eff;
  logic [DvW-1:0]           dv_full, dv;
  logic [DhW-1:0]           dh_full, dh;
  logic signed [SumW-1:0]   ax, ay, dvs, dhs, px, py, advs, sx, sy;

  assign anchor_x = $signed(s_axis_tdata[InAnchorXLsb +: CoordW]);
  assign anchor_y = $signed(s_axis_tdata[InAnchorYLsb +: CoordW]);
  assign text_len = s_axis_tdata[InLengthLsb +: 8];
  assign code     = s_axis_tdata[InCodeLsb +: 7];

  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (size_q == '0) begin
      eff = SizeW'(1);
    end else if (int'(size_q) > MaxPixelSize) begin
      eff = SizeW'(MaxPixelSize);
    end else begin
      eff = size_q;
    end
  end

  always_comb begin
    dv_full = RowsV * {{(DvW-SizeW){1'b0}}, eff};
    dh_full = {4'b0000, text_len, 3'b000} * {{(DhW-SizeW){1'b0}}, eff};
    if (jv_q == JustNone) begin
      dv = '0;
    end else if (jv_q == JustHalf) begin
      dv = dv_full >> 1;
    end else begin
      dv = dv_full;
    end
    if (jh_q == JustNone) begin
      dh = '0;
    end else if (jh_q == JustHalf) begin
      dh = dh_full >> 1;
    end else begin
      dh = dh_full;
    end
    ax   = SumW'(anchor_x);
    ay   = SumW'(anchor_y);
    dvs  = $signed({{(SumW-DvW){1'b0}}, dv});
    dhs  = $signed({{(SumW-DhW){1'b0}}, dh});
    advs = $signed({{(SumW-SizeW-3){1'b0}}, eff, 3'b000});
    sx   = SumW'(pen_x_q);
    sy   = SumW'(pen_y_q);
    px   = sx;
    py   = sy;
    if (s_axis_tuser == CmdStart) begin
      unique case (dir_q)
        DirDown: begin
          px = ax + dvs;
          py = ay - dhs;
        end
        DirLeft: begin
          px = ax + dhs;
          py = ay + dvs;
        end
        DirUp: begin
          px = ax - dvs;
          py = ay + dhs;
        end
        DirRight: begin
          px = ax - dhs;
          py = ay - dvs;
        end
      endcase
    end else begin
      unique case (dir_q)
        DirDown:  py = sy + advs;
        DirLeft:  px = sx - advs;
        DirUp:    py = sy - advs;
        DirRight: px = sx + advs;
      endcase
    end
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    if (accept) begin
      pen_x_d = sat16(px);
      pen_y_d = sat16(py);
    end
  end

  assign q_push_o       = accept && (s_axis_tuser == CmdDraw);
  assign q_data_o.pen_x = pen_x_q;
  assign q_data_o.pen_y = pen_y_q;
  assign q_data_o.dir   = dir_q;
  assign q_data_o.size  = eff;
  assign q_data_o.base  = FontAddrW'(code) * FontAddrW'(GLYPH_ROWS);
  assign q_data_o.blank = int'(code) >= GLYPH_COUNT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= DirRight;
      size_q  <= SizeW'(1);
      jh_q    <= JustNone;
      jv_q    <= JustNone;
      pen_x_q <= '0;
      pen_y_q <= '0;
    end else begin
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegDirection: dir_q  <= cfg_data_i[1:0];
          RegPixelSize: size_q <= cfg_data_i;
          RegJustHoriz: jh_q   <= cfg_data_i[1:0];
          RegJustVert:  jv_q   <= cfg_data_i[1:0];
        endcase
      end
    end
  end

endmodule

/* rtl/core/btgr_queue.sv */
// ----------------------------------------------------------------------------
// btgr_queue
// Short first-in first-out queue of characters between front and back.
// ----------------------------------------------------------------------------
module btgr_queue import btgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  btgr_glyph_t data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output btgr_glyph_t data_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  btgr_glyph_t      mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= QueueDepth)
    else $error("queue count out of range");

endmodule

/* rtl/core/btgr_back.sv */
// ----------------------------------------------------------------------------
// btgr_back
// Walks the glyph rows of the head character, one per cycle unless stalled: row
// position stage, then font lookup into the output register.
// ----------------------------------------------------------------------------
module btgr_back import btgr_pkg::*; #(
  parameter int GLYPH_ROWS = GlyphRows
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  btgr_glyph_t         q_data_i,
  output logic                q_pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  localparam int RowW   = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int OffMax = (GLYPH_ROWS - 1) * MaxPixelSize;
  localparam int OffW   = (OffMax > 0) ? $clog2(OffMax + 1) : 1;
  localparam logic [RowW-1:0] LastRow = RowW'(GLYPH_ROWS - 1);

  logic [RowW-1:0] row_q, row_d;
  logic [OffW-1:0] off_q, off_d;
  logic            en, issue, at_last;

  logic signed [SumW-1:0]   pxs, pys, offs;
  logic signed [CoordW-1:0] rx, ry;
  logic signed [StepW-1:0]  stx, sty, szs;

  logic                     s1_valid_q;
  logic signed [CoordW-1:0] s1_x_q, s1_y_q;
  logic signed [StepW-1:0]  s1_sx_q, s1_sy_q;
  logic [FontAddrW-1:0]     s1_addr_q;
  logic                     s1_blank_q, s1_last_q;

  logic                     out_valid_q;
  logic signed [CoordW-1:0] out_x_q, out_y_q;
  logic signed [StepW-1:0]  out_sx_q, out_sy_q;
  logic [GlyphCols-1:0]     out_mask_q;
  logic                     out_last_q;

  assign en      = !out_valid_q || m_axis_tready;
  assign issue   = q_valid_i && en;
  assign at_last = row_q == LastRow;
  assign q_pop_o = issue && at_last;

  always_comb begin
    row_d = row_q;
    off_d = off_q;
    if (issue) begin
      if (at_last) begin
        row_d = '0;
        off_d = '0;
      end else begin
        row_d = row_q + RowW'(1);
        off_d = off_q + OffW'(q_data_i.size);
      end
    end
  end

  // row origin and column step for the current row
  always_comb begin
    pxs  = SumW'(q_data_i.pen_x);
    pys  = SumW'(q_data_i.pen_y);
    offs = $signed({{(SumW-OffW){1'b0}}, off_q});
    szs  = $signed({1'b0, q_data_i.size});
    unique case (q_data_i.dir)
      DirDown: begin
        pxs = pxs - offs;
        stx = '0;
        sty = szs;
      end
      DirLeft: begin
        pys = pys - offs;
        stx = -szs;
        sty = '0;
      end
      DirUp: begin
        pxs = pxs + offs;
        stx = '0;
        sty = -szs;
      end
      DirRight: begin
        pys = pys + offs;
        stx = szs;
        sty = '0;
      end
    endcase
    rx = sat16(pxs);
    ry = sat16(pys);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      off_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_q <= row_d;
      off_q <= off_d;
      if (en) begin
        s1_valid_q  <= q_valid_i;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q     <= rx;
      s1_y_q     <= ry;
      s1_sx_q    <= stx;
      s1_sy_q    <= sty;
      s1_addr_q  <= q_data_i.base + FontAddrW'(row_q);
      s1_blank_q <= q_data_i.blank;
      s1_last_q  <= at_last;
      out_x_q    <= s1_x_q;
      out_y_q    <= s1_y_q;
      out_sx_q   <= s1_sx_q;
      out_sy_q   <= s1_sy_q;
      out_mask_q <= s1_blank_q ? '0 : font_byte(s1_addr_q);
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OutDataW - 2*CoordW - 2*StepW - GlyphCols){1'b0}},
                          out_mask_q, out_sy_q, out_sx_q, out_y_q, out_x_q};

  // first row starts at the pen, later rows are at least one size away
  a_off_tracks_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q == '0) == (off_q == '0))
    else $error("row offset out of step with row count");

  // a character stays at the queue head until its last row is issued
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q != '0) |-> q_valid_i)
    else $error("queue head lost in the middle of a glyph");

  a_stall_holds_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(row_q) && $stable(s1_addr_q))
    else $error("row walk moved under back-pressure");

endmodule

/* rtl/core/bitmap_text_glyph_renderer.sv */
// ----------------------------------------------------------------------------
// bitmap_text_glyph_renderer
// 8x12 bitmap font text renderer: pen placement, justification and glyph
// row output with position, column step and pixel mask.
// ----------------------------------------------------------------------------
// A start transaction yields no output.
// A character transaction yields GLYPH_ROWS row transactions through the
// queue, the row position stage and the output register; rows follow one
// per cycle while the output is not stalled. The row walker in the back end
// sets the rate; inputs are taken while the two-entry queue has room.
// Reset clears the pen to (0,0), direction right, pixel size 1, no justify.
module bitmap_text_glyph_renderer import btgr_pkg::*; #(
  parameter int GLYPH_COUNT = GlyphCount,
  parameter int GLYPH_ROWS  = GlyphRows
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // anchor_x[15:0], anchor_y[31:16], text_length[39:32], char_code[46:40]
  input  logic [InDataW-1:0]   s_axis_tdata,
  // cmd
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // row_x[15:0], row_y[31:16], step_x[36:32], step_y[41:37], row_mask[49:42]
  output logic [OutDataW-1:0]  m_axis_tdata,
  // last_row
  output logic                 m_axis_tlast
);

  logic        q_full, q_push, q_pop, q_valid;
  btgr_glyph_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  btgr_front #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .GLYPH_ROWS  (GLYPH_ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_in)
  );

  btgr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  btgr_back #(
    .GLYPH_ROWS (GLYPH_ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_out),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* tb/bitmap_text_glyph_renderer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_text_glyph_renderer_tb
// Streams start and character transactions into the glyph renderer under
// several direction, scale and justification settings. An in-bench pen and
// font model predicts every row transaction, and each row is checked field
// by field. Both stream sides idle at random, and the row side once holds
// off for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module bitmap_text_glyph_renderer_tb import btgr_pkg::*;;

  localparam int RowsPerGlyph = 12;
  localparam int PauseCycles  = 16;
  localparam int QuietLimit   = 3000;
  localparam int HoldAt       = 150;
  localparam int HoldCycles   = 300;

  localparam logic [1:0] JustFull    = 2'd2;
  localparam logic [1:0] JustFullAlt = 2'd3;

  // 8x12 font, four glyph rows per word, lowest byte first
  localparam logic [31:0] GlyphBits [384] = '{
    32'd0, 32'd0, 32'd0, 32'd2177072640,
    32'd2579333541, 32'd32451, 32'd4294934016, 32'd3888381915,
    32'd32511, 32'd1998716928, 32'd1048543103, 32'd2076,
    32'd1042024448, 32'd473857919, 32'd8, 32'd1010571264,
    32'd417851391, 32'd32280, 32'd2117867520, 32'd410976255,
    32'd32280, 32'd0, 32'd1014922812, 32'd0,
    32'd4294967295, 32'd3280044483, 32'd4294967295, 32'd2117861376,
    32'd1715618406, 32'd15486, 32'd2177105919, 32'd2579348889,
    32'd4294951809, 32'd1550875648, 32'd858988366, 32'd7731,
    32'd1717976064, 32'd2115517542, 32'd6168, 32'd2560161792,
    32'd504895736, 32'd3615, 32'd4274454016, 32'd3871786694,
    32'd223207, 32'd3675783168, 32'd2129127294, 32'd6363,
    32'd117637376, 32'd119504671, 32'd259, 32'd1885356032,
    32'd1887207292, 32'd16480, 32'd2117867520, 32'd2115508248,
    32'd6204, 32'd1717986816, 32'd26214, 32'd26214,
    32'd3688627712, 32'd3638091483, 32'd55512, 32'd214334976,
    32'd1013343804, 32'd8282928, 32'd0, 32'd2130706432,
    32'd32639, 32'd2117867520, 32'd2115508248, 32'd8263740,
    32'd2117867520, 32'd404232216, 32'd6168, 32'd404232192,
    32'd2115508248, 32'd6204, 32'd402653184, 32'd405831472,
    32'd0, 32'd201326592, 32'd201752326, 32'd0,
    32'd0, 32'd2130903811, 32'd0, 32'd603979776,
    32'd610729830, 32'd0, 32'd134742016, 32'd1044257820,
    32'd32639, 32'd2139029504, 32'd471612990, 32'd2056,
    32'd0, 32'd0, 32'd0, 32'd505285632,
    32'd789534, 32'd3084, 32'd1717986816, 32'd36,
    32'd0, 32'd2134259200, 32'd2134259254, 32'd13878,
    32'd54397964, 32'd808459779, 32'd789535, 32'd587202560,
    32'd101455923, 32'd12595, 32'd454757888, 32'd863723278,
    32'd28219, 32'd202116096, 32'd6, 32'd0,
    32'd202911744, 32'd201721350, 32'd12312, 32'd403441152,
    32'd405811248, 32'd1548, 32'd1711276032, 32'd1715273532,
    32'd0, 32'd402653184, 32'd404258328, 32'd0,
    32'd0, 32'd0, 32'd400412, 32'd0,
    32'd32512, 32'd0, 32'd0, 32'd0,
    32'd7196, 32'd1614807040, 32'd101455920, 32'd259,
    32'd1935883776, 32'd1735355259, 32'd15971, 32'd252446720,
    32'd202116108, 32'd16140, 32'd858988032, 32'd101455920,
    32'd16179, 32'd808656384, 32'd808459312, 32'd7731,
    32'd1010315264, 32'd813642550, 32'd30768, 32'd50544384,
    32'd808460035, 32'd7731, 32'd50732032, 32'd858988291,
    32'd7731, 32'd1667464960, 32'd202911840, 32'd3084,
    32'd858988032, 32'd859512375, 32'd7731, 32'd858988032,
    32'd404241971, 32'd3596, 32'd469762048, 32'd469762076,
    32'd28, 32'd469762048, 32'd469762076, 32'd792604,
    32'd202911744, 32'd201720582, 32'd12312, 32'd0,
    32'd8257662, 32'd0, 32'd403441152, 32'd405823536,
    32'd1548, 32'd808656384, 32'd789528, 32'd3084,
    32'd1667448320, 32'd58424187, 32'd15875, 32'd857607168,
    32'd859779891, 32'd13107, 32'd1717976832, 32'd1717976678,
    32'd16230, 32'd1667644416, 32'd1661141763, 32'd15462,
    32'd1714822912, 32'd1717986918, 32'd7990, 32'd105283328,
    32'd103169574, 32'd32582, 32'd1181122304, 32'd103169574,
    32'd3846, 32'd1667644416, 32'd1668481795, 32'd31846,
    32'd858993408, 32'd858996531, 32'd13107, 32'd202120704,
    32'd202116108, 32'd7692, 32'd808482816, 32'd858992688,
    32'd7731, 32'd912680704, 32'd909516342, 32'd26470,
    32'd101060352, 32'd1715865094, 32'd32614, 32'd2138530560,
    32'd1667459967, 32'd25443, 32'd1734566656, 32'd1937473391,
    32'd25443, 32'd1664490496, 32'd1667457891, 32'd7222,
    32'd1717976832, 32'd101072486, 32'd3846, 32'd1664490496,
    32'd2071159651, 32'd7876670, 32'd1717976832, 32'd1714830950,
    32'd26470, 32'd858988032, 32'd857214467, 32'd7731,
    32'd204291840, 32'd202116108, 32'd7692, 32'd858993408,
    32'd858993459, 32'd7731, 32'd858993408, 32'd858993459,
    32'd3102, 32'd1667457792, 32'd913009507, 32'd13878,
    32'd858993408, 32'd857607198, 32'd13107, 32'd858993408,
    32'd202120755, 32'd7692, 32'd426999552, 32'd1174801432,
    32'd32611, 32'd202128384, 32'd202116108, 32'd15372,
    32'd50397184, 32'd806882310, 32'd16480, 32'd808467456,
    32'd808464432, 32'd15408, 32'd1664490504, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd16711680,
    32'd1575948, 32'd0, 32'd0, 32'd0,
    32'd859713566, 32'd28211, 32'd101058304, 32'd1717986878,
    32'd15206, 32'd0, 32'd50541342, 32'd7731,
    32'd808466432, 32'd858993470, 32'd28211, 32'd0,
    32'd54473502, 32'd7731, 32'd104209408, 32'd101064454,
    32'd3846, 32'd0, 32'd858993518, 32'd506671166,
    32'd101058304, 32'd1717988918, 32'd26470, 32'd1579008,
    32'd404232222, 32'd32280, 32'd3158016, 32'd808464444,
    32'd506671920, 32'd101058304, 32'd907949670, 32'd26470,
    32'd404233728, 32'd404232216, 32'd32280, 32'd0,
    32'd1802201919, 32'd25451, 32'd0, 32'd858993439,
    32'd13107, 32'd0, 32'd858993438, 32'd7731,
    32'd0, 32'd1717986875, 32'd252067430, 32'd0,
    32'd858993518, 32'd2016427571, 32'd0, 32'd107902519,
    32'd3846, 32'd0, 32'd403059486, 32'd7731,
    32'd100925440, 32'd101058111, 32'd7222, 32'd0,
    32'd858993459, 32'd28211, 32'd0, 32'd858993459,
    32'd3102, 32'd0, 32'd1802199907, 32'd13878,
    32'd0, 32'd471610979, 32'd25398, 32'd0,
    32'd1717986918, 32'd253243452, 32'd0, 32'd102248767,
    32'd16163, 32'd202127360, 32'd201720582, 32'd14348,
    32'd404232192, 32'd404226072, 32'd6168, 32'd202114816,
    32'd202911768, 32'd1804, 32'd1935396352, 32'd0,
    32'd0, 32'd134217728, 32'd1667446300, 32'd127
  };

  typedef struct packed {
    logic               cmd;
    logic [InDataW-1:0] data;
  } text_item_t;

  typedef struct packed {
    logic [15:0] row_x;
    logic [15:0] row_y;
    logic [4:0]  step_x;
    logic [4:0]  step_y;
    logic [7:0]  mask;
    logic        last;
  } glyph_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;

  bitmap_text_glyph_renderer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  text_item_t text_queue[$];
  glyph_row_t pending_rows[$];
  int         items_pushed   = 0;
  int         items_taken    = 0;
  int         mismatch_count = 0;
  int         feed_gap_pct   = 24;
  int         drain_gap_pct  = 78;
  int         hold_left      = 0;
  bit         hold_done      = 1'b0;
  int         quiet_cycles   = 0;

  // pen and register copy used for prediction
  int         pen_x_q = 0;
  int         pen_y_q = 0;
  logic [1:0] dir_q   = DirRight;
  logic [3:0] size_q  = 4'd1;
  logic [1:0] jh_q    = JustNone;
  logic [1:0] jv_q    = JustNone;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [7:0] glyph_row_bits(logic [6:0] code, int row);
    int          addr;
    logic [31:0] word;
    addr = int'(code) * RowsPerGlyph + row;
    word = GlyphBits[addr >> 2];
    return word[(addr % 4) * 8 +: 8];
  endfunction

  task automatic trace_text_item(logic cmd, logic [InDataW-1:0] d);
    int         s;
    int         px;
    int         py;
    int         off;
    int         sx;
    int         sy;
    int         c;
    int         i;
    glyph_row_t r;
    s = (size_q == 4'd0) ? 1 : ((size_q > 4'd10) ? 10 : int'(size_q));
    if (cmd == CmdStart) begin
      px = int'($signed(d[InAnchorXLsb +: CoordW]));
      py = int'($signed(d[InAnchorYLsb +: CoordW]));
      if (jv_q != JustNone) begin
        off = RowsPerGlyph * s;
        if (jv_q == JustHalf) off = off / 2;
        case (dir_q)
          DirDown: px += off;
          DirLeft: py += off;
          DirUp:   px -= off;
          default: py -= off;
        endcase
      end
      if (jh_q != JustNone) begin
        off = int'(d[InLengthLsb +: 8]) * 8 * s;
        if (jh_q == JustHalf) off = off / 2;
        case (dir_q)
          DirDown: py -= off;
          DirLeft: px += off;
          DirUp:   py += off;
          default: px -= off;
        endcase
      end
      pen_x_q = clamp16(px);
      pen_y_q = clamp16(py);
    end else begin
      case (dir_q)
        DirDown: begin sx = 0;  sy = s;  end
        DirLeft: begin sx = -s; sy = 0;  end
        DirUp:   begin sx = 0;  sy = -s; end
        default: begin sx = s;  sy = 0;  end
      endcase
      for (i = 0; i < RowsPerGlyph; i++) begin
        px = pen_x_q;
        py = pen_y_q;
        case (dir_q)
          DirDown: px -= i * s;
          DirLeft: py -= i * s;
          DirUp:   px += i * s;
          default: py += i * s;
        endcase
        c = clamp16(px);
        r.row_x = c[15:0];
        c = clamp16(py);
        r.row_y = c[15:0];
        r.step_x = sx[4:0];
        r.step_y = sy[4:0];
        r.mask = glyph_row_bits(d[InCodeLsb +: 7], i);
        r.last = (i == RowsPerGlyph - 1);
        pending_rows = {pending_rows, r};
      end
      case (dir_q)
        DirDown: pen_y_q = clamp16(pen_y_q + 8 * s);
        DirLeft: pen_x_q = clamp16(pen_x_q - 8 * s);
        DirUp:   pen_y_q = clamp16(pen_y_q - 8 * s);
        default: pen_x_q = clamp16(pen_x_q + 8 * s);
      endcase
    end
  endtask

  task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---- stimulus helpers ----

  task automatic push_start(logic [15:0] ax, logic [15:0] ay, logic [7:0] len);
    text_item_t it;
    logic [6:0] junk;
    junk = 7'($urandom_range(127));
    it.cmd = CmdStart;
    it.data = {1'b0, junk, len, ay, ax};
    text_queue = {text_queue, it};
    items_pushed++;
  endtask

  task automatic push_draw(logic [6:0] code);
    text_item_t  it;
    logic [31:0] junk;
    logic [7:0]  junk_len;
    junk = $urandom;
    junk_len = 8'($urandom_range(255));
    it.cmd = CmdDraw;
    it.data = {1'b0, code, junk_len, junk};
    text_queue = {text_queue, it};
    items_pushed++;
  endtask

  // coordinates biased toward the saturation edges and the origin
  function automatic logic [15:0] pick_coord();
    int v;
    case ($urandom_range(3))
      0:       v = $urandom;
      1:       v = 32767 - int'($urandom_range(200));
      2:       v = -32768 + int'($urandom_range(200));
      default: v = int'($urandom_range(400)) - 200;
    endcase
    return v[15:0];
  endfunction

  task automatic random_text(int count);
    int         made;
    int         n;
    int         roll;
    logic [7:0] len;
    logic [6:0] code;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        n = $urandom_range(8, 1);
        len = $urandom_range(1) ? n[7:0] : 8'($urandom_range(255));
        push_start(pick_coord(), pick_coord(), len);
        repeat (n) begin
          code = 7'($urandom_range(127));
          push_draw(code);
        end
        made += n + 1;
      end else if (roll < 90) begin
        n = $urandom_range(3, 1);
        repeat (n) begin
          code = 7'($urandom_range(127));
          push_draw(code);
        end
        made += n;
      end else begin
        len = 8'($urandom_range(255));
        push_start(pick_coord(), pick_coord(), len);
        made++;
      end
    end
  endtask

  // wait until every transaction is taken and every row has come out
  task automatic settle();
    do @(posedge clk_i);
    while (items_taken != items_pushed || pending_rows.size() != 0);
    repeat (PauseCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [1:0] dir, logic [3:0] size, logic [1:0] jh,
                           logic [1:0] jv);
    logic [1:0] hi;
    settle();
    // upper data bits are don't-care for the 2-bit registers
    hi = 2'($urandom_range(3));
    write_reg(RegDirection, {hi, dir});
    write_reg(RegPixelSize, size);
    hi = 2'($urandom_range(3));
    write_reg(RegJustHoriz, {hi, jh});
    hi = 2'($urandom_range(3));
    write_reg(RegJustVert, {hi, jv});
    @(negedge clk_i);
  endtask

  // ---- stream driver ----

  always @(posedge clk_i) begin
    text_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (text_queue.size() != 0 && $urandom_range(99) >= feed_gap_pct) begin
        nxt = text_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.cmd;
        s_axis_tdata  <= nxt.data;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= drain_gap_pct);
    end
  end

  // one long back-pressure stretch so the input queue fills
  always @(posedge clk_i) begin
    if (rst_ni && !hold_done && items_taken >= HoldAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---- monitor and row check ----

  always @(posedge clk_i) begin
    glyph_row_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegDirection: dir_q  = cfg_data_i[1:0];
          RegPixelSize: size_q = cfg_data_i;
          RegJustHoriz: jh_q   = cfg_data_i[1:0];
          RegJustVert:  jv_q   = cfg_data_i[1:0];
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        trace_text_item(s_axis_tuser, s_axis_tdata);
        items_taken <= items_taken + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_rows.size() == 0) begin
          note_mismatch("row with no character pending", m_axis_tdata[15:0], 16'h0);
        end else begin
          want = pending_rows.pop_front();
          if (m_axis_tdata[15:0] !== want.row_x)
            note_mismatch("row_x", m_axis_tdata[15:0], want.row_x);
          if (m_axis_tdata[31:16] !== want.row_y)
            note_mismatch("row_y", m_axis_tdata[31:16], want.row_y);
          if (m_axis_tdata[36:32] !== want.step_x)
            note_mismatch("step_x", 16'(m_axis_tdata[36:32]), 16'(want.step_x));
          if (m_axis_tdata[41:37] !== want.step_y)
            note_mismatch("step_y", 16'(m_axis_tdata[41:37]), 16'(want.step_y));
          if (m_axis_tdata[49:42] !== want.mask)
            note_mismatch("row_mask", 16'(m_axis_tdata[49:42]), 16'(want.mask));
          if (m_axis_tlast !== want.last)
            note_mismatch("last_row", 16'(m_axis_tlast), 16'(want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---- test sequence ----

  initial begin
    int         ph;
    logic [3:0] sz;
    logic [1:0] jh;
    logic [1:0] jv;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings; characters before any start draw from the origin
    push_draw(7'd0);
    push_draw(7'd127);
    push_start(16'h7FFF, 16'h7FFF, 8'd255);
    push_draw(7'd65);
    push_draw(7'd66);
    push_start(16'h8000, 16'h8000, 8'd0);
    push_draw(7'd1);

    // size zero and justify code three
    configure(DirLeft, 4'd0, JustFullAlt, JustFullAlt);
    push_start(16'h8000, 16'h7FFF, 8'd255);
    push_draw(7'd127);
    push_draw(7'd32);

    // size above the maximum, half offsets
    configure(DirUp, 4'd15, JustHalf, JustHalf);
    push_start(16'h0000, 16'h0000, 8'd1);
    push_draw(7'h55);
    push_start(16'h7FFF, 16'h8000, 8'd255);
    push_draw(7'h2A);

    configure(DirDown, 4'd10, JustFull, JustNone);
    push_start(16'h8000, 16'h8000, 8'd255);
    push_draw(7'h7F);
    push_draw(7'h40);

    configure(DirRight, 4'd5, JustNone, JustFull);
    push_start(16'd100, 16'hFF9C, 8'd3);
    push_draw(7'd72);
    push_draw(7'd105);

    for (ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       sz = 4'd1;
        1:       sz = 4'd10;
        2:       sz = 4'd0;
        3:       sz = 4'd15;
        default: sz = 4'($urandom_range(15));
      endcase
      jh = 2'($urandom_range(3));
      jv = 2'($urandom_range(3));
      configure(ph[1:0], sz, jh, jv);
      if (ph == 4) begin
        feed_gap_pct  = 78;
        drain_gap_pct = 24;
      end
      if (ph == 8) begin
        feed_gap_pct  = 0;
        drain_gap_pct = 0;
      end
      random_text(34);
    end

    settle();
    if (mismatch_count == 0 && pending_rows.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/btgr_pkg.sv
rtl/core/btgr_front.sv
rtl/core/btgr_queue.sv
rtl/core/btgr_back.sv
rtl/core/bitmap_text_glyph_renderer.sv
tb/bitmap_text_glyph_renderer_tb.sv
